@@ rtl/great_circle_distance_defines.svh @@
// Assertion macros for the great-circle distance block.
// Taken in by the top level; no other dependencies.
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define GCD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("great_circle_distance: assertion failed");

// Implication with a fixed delay in cycles
`define GCD_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##(dly) (cons)) \
    else $error("great_circle_distance: assertion failed");

`endif

@@ rtl/gcd_pkg.sv @@
// Shared types, constants and constant tables for the great-circle distance block.
// No dependencies.
package gcd_pkg;

  // Field widths
  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int DW    = 25;

  // Fixed-point format and CORDIC depth
  localparam int FRAC      = 30;
  localparam int STEPS     = 32;
  localparam int ISQ_STEPS = 32;
  localparam int LANES     = 3;
  localparam int AW        = 34;       // angles, sines, cosines
  localparam int SW        = AW + 1;   // cosine sum
  localparam int UW        = LON_W + 1; // microdegrees incl. longitude difference
  localparam int MW        = 27;       // reduced magnitude, up to 90e6
  localparam int ISW       = 63;       // integer square root datapath
  localparam int TAB_Q     = 56;

  // Pipeline depths
  localparam int TRIG_LAT = 4 + STEPS;
  localparam int ACOS_LAT = 3 + ISQ_STEPS + STEPS;

  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] RSQRT2_Q56 = 64'h00B504F333F9DE64;
  localparam logic [63:0] RAD_DIV    = 64'd11250000;

  // pi / 180e6 scaled by 2^72, split for two narrow multipliers
  localparam logic [63:0] RAD_PER_UDEG =
    ((PI_Q60 / RAD_DIV) << 8) + (((PI_Q60 % RAD_DIV) << 8) / RAD_DIV);
  localparam int RAD_LO_W  = 24;
  localparam int RAD_HI_W  = 23;
  localparam int RAD_SHIFT = 72 - FRAC;
  localparam logic [RAD_LO_W-1:0] RAD_LO = RAD_PER_UDEG[RAD_LO_W-1:0];
  localparam logic [RAD_HI_W-1:0] RAD_HI = RAD_PER_UDEG[RAD_LO_W +: RAD_HI_W];

  localparam logic signed [UW-1:0] UDEG_90  = UW'(90000000);
  localparam logic signed [UW-1:0] UDEG_180 = UW'(180000000);
  localparam logic signed [UW-1:0] UDEG_360 = UW'(360000000);

  localparam logic signed [AW-1:0] PI_F =
    AW'((PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));

  localparam logic [22:0] METER_SCALE = 23'd6314220;

  // Control that travels with each beat
  typedef struct packed {
    logic valid;
    logic same;
  } tag_t;

  function automatic logic [63:0] q56_to_f(input logic [63:0] v);
    return (v + (64'd1 << (TAB_Q - FRAC - 1))) >> (TAB_Q - FRAC);
  endfunction

  // atan(2^-i) from its series (pi/4 for i = 0), rounded into the angle format
  function automatic logic signed [AW-1:0] atan_f(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          sh;
    int          dv;
    sum = '0;
    if (i == 0) begin
      sum = PI_Q60 >> 6;
    end else begin
      for (int k = 0; k < TAB_Q; k++) begin
        sh = i * (2 * k + 1);
        if (sh <= TAB_Q) begin
          dv   = 2 * k + 1;
          term = (64'd1 << (TAB_Q - sh)) / 64'(dv);
          if (k[0]) sum = sum - term;
          else      sum = sum + term;
        end
      end
    end
    return AW'(q56_to_f(sum));
  endfunction

  // CORDIC gain from the binomial series of each step
  function automatic logic signed [AW-1:0] gain_f();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    logic        done;
    p = RSQRT2_Q56;
    for (int i = 1; i < STEPS; i++) begin
      if (2 * i < TAB_Q) begin
        sum  = p;
        t    = p;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
          if (!done) begin
            t = ((t >> (2 * i)) * 64'(2 * k - 1)) / 64'(2 * k);
            if (t == '0)  done = 1'b1;
            else if (k[0]) sum = sum - t;
            else           sum = sum + t;
          end
        end
        p = sum;
      end
    end
    return AW'(q56_to_f(p));
  endfunction

  localparam logic signed [AW-1:0] GAIN_F = gain_f();

endpackage

@@ rtl/gcd_trig.sv @@
// Three-lane cosine/sine pipeline on angles in microdegrees: range
// reduction, degree-to-radian scaling and an unrolled rotation CORDIC. Uses gcd_pkg.
module gcd_trig (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gcd_pkg::tag_t                  tag_i,
  input  logic signed [gcd_pkg::UW-1:0]  udeg_i [gcd_pkg::LANES],
  output gcd_pkg::tag_t                  tag_o,
  output logic signed [gcd_pkg::AW-1:0]  cos_o  [gcd_pkg::LANES],
  output logic signed [gcd_pkg::AW-1:0]  sin_o  [gcd_pkg::LANES]
);
  import gcd_pkg::*;

  localparam int PLO_W  = MW + RAD_LO_W;
  localparam int PHI_W  = MW + RAD_HI_W;
  localparam int PROD_W = PHI_W + RAD_LO_W + 1;

  tag_t tag_q [TRIG_LAT];

  // Tag line alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TRIG_LAT; j++) tag_q[j] <= '0;
    end else begin
      tag_q[0] <= tag_i;
      for (int j = 1; j < TRIG_LAT; j++) tag_q[j] <= tag_q[j-1];
    end
  end

  assign tag_o = tag_q[TRIG_LAT-1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [UW-1:0] wrap_d, wrap_q;
    logic [MW-1:0]        mag_d, mag_q;
    logic                 neg_d, neg_q, negb_q;
    logic                 flip_d, flipa_q, flipb_q;
    logic [PLO_W-1:0]     plo_q;
    logic [PHI_W-1:0]     phi_q;
    logic [PROD_W-1:0]    prod;
    logic signed [AW-1:0] z_d;
    logic signed [AW-1:0] x_q [STEPS+1];
    logic signed [AW-1:0] y_q [STEPS+1];
    logic signed [AW-1:0] z_q [STEPS];
    logic                 flip_q [STEPS];

    // Stage 1: remainder by 360 degrees, then wrap into (-180, 180]
    always_comb begin
      logic signed [UW-1:0] m;
      m = udeg_i[l];
      if (m >= UDEG_360)       m = m - UDEG_360;
      else if (m <= -UDEG_360) m = m + UDEG_360;
      if (m > UDEG_180)        m = m - UDEG_360;
      else if (m <= -UDEG_180) m = m + UDEG_360;
      wrap_d = m;
    end

    // Stage 2: fold into [-90, 90], remember the cosine sign flip
    always_comb begin
      logic signed [UW-1:0] a;
      a      = wrap_q;
      flip_d = 1'b0;
      if (a > UDEG_90) begin
        a      = UDEG_180 - a;
        flip_d = 1'b1;
      end else if (a < -UDEG_90) begin
        a      = -UDEG_180 - a;
        flip_d = 1'b1;
      end
      neg_d = a[UW-1];
      mag_d = neg_d ? MW'(-a) : MW'(a);
    end

    // Stage 4: join partial products, scale to radians, restore sign
    always_comb begin
      logic [AW-1:0] r;
      prod = PROD_W'({phi_q, {RAD_LO_W{1'b0}}}) + PROD_W'(plo_q);
      r    = {1'b0, prod[RAD_SHIFT +: AW-1]};
      z_d  = negb_q ? -signed'(r) : signed'(r);
    end

    always_ff @(posedge clk_i) begin
      wrap_q    <= wrap_d;
      mag_q     <= mag_d;
      neg_q     <= neg_d;
      flipa_q   <= flip_d;
      plo_q     <= PLO_W'(mag_q) * PLO_W'(RAD_LO);
      phi_q     <= PHI_W'(mag_q) * PHI_W'(RAD_HI);
      negb_q    <= neg_q;
      flipb_q   <= flipa_q;
      x_q[0]    <= GAIN_F;
      y_q[0]    <= '0;
      z_q[0]    <= z_d;
      flip_q[0] <= flipb_q;
    end

    // Rotation CORDIC, one micro-rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [AW-1:0] xn, yn;

      always_comb begin
        if (z_q[i] >= 0) begin
          xn = x_q[i] - (y_q[i] >>> i);
          yn = y_q[i] + (x_q[i] >>> i);
        end else begin
          xn = x_q[i] + (y_q[i] >>> i);
          yn = y_q[i] - (x_q[i] >>> i);
        end
      end

      if (i < STEPS - 1) begin : g_mid
        localparam logic signed [AW-1:0] ATAN_I = atan_f(i);
        always_ff @(posedge clk_i) begin
          x_q[i+1]    <= xn;
          y_q[i+1]    <= yn;
          z_q[i+1]    <= (z_q[i] >= 0) ? z_q[i] - ATAN_I : z_q[i] + ATAN_I;
          flip_q[i+1] <= flip_q[i];
        end
      end else begin : g_last
        // cosine takes the fold's sign here
        always_ff @(posedge clk_i) begin
          x_q[i+1] <= flip_q[i] ? -xn : xn;
          y_q[i+1] <= yn;
        end
      end
    end

    assign cos_o[l] = x_q[STEPS];
    assign sin_o[l] = y_q[STEPS];
  end

endmodule

@@ rtl/gcd_acos.sv @@
// Arc cosine pipeline: clamp, 1 - s^2, digit-by-digit square root and an
// unrolled vectoring CORDIC. Uses gcd_pkg.
module gcd_acos (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gcd_pkg::tag_t                 tag_i,
  input  logic signed [gcd_pkg::SW-1:0] sum_i,
  output gcd_pkg::tag_t                 tag_o,
  output logic [gcd_pkg::AW-1:0]        angle_o
);
  import gcd_pkg::*;

  localparam int AMW = FRAC + 1;
  localparam int OPW = FRAC + 2;
  localparam logic signed [SW-1:0] ONE_S = SW'(64'd1 << FRAC);
  localparam logic [OPW-1:0]       ONE_W = OPW'(64'd1 << FRAC);

  tag_t tag_q [ACOS_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ACOS_LAT; j++) tag_q[j] <= '0;
    end else begin
      tag_q[0] <= tag_i;
      for (int j = 1; j < ACOS_LAT; j++) tag_q[j] <= tag_q[j-1];
    end
  end

  assign tag_o = tag_q[ACOS_LAT-1];

  logic [AMW-1:0]       a_d;
  logic                 neg_d;
  logic [AMW-1:0]       a1_q;
  logic                 neg1_q;
  logic [OPW-1:0]       sub_a, add_a;
  logic [ISW-1:0]       n_q   [ISQ_STEPS];
  logic [ISW-1:0]       r_q   [ISQ_STEPS+1];
  logic [AMW-1:0]       sa_q  [ISQ_STEPS+1];
  logic                 sn_q  [ISQ_STEPS+1];
  logic signed [AW-1:0] vx_q  [1:STEPS-1];
  logic signed [AW-1:0] vy_q  [1:STEPS-1];
  logic signed [AW-1:0] vz_q  [1:STEPS];
  logic                 vn_q  [1:STEPS];
  logic signed [AW-1:0] zc;
  logic [AW-1:0]        ang_q;

  // Stage 1: clamp to [-1, 1], split into sign and magnitude
  always_comb begin
    logic signed [SW-1:0] s;
    s = sum_i;
    if (s > ONE_S)       s = ONE_S;
    else if (s < -ONE_S) s = -ONE_S;
    neg_d = s[SW-1];
    a_d   = neg_d ? AMW'(-s) : AMW'(s);
  end

  // Stage 2: (1 - a)(1 + a); never reaches 2^62, so no pre-shift is needed
  assign sub_a = ONE_W - OPW'(a1_q);
  assign add_a = ONE_W + OPW'(a1_q);

  always_ff @(posedge clk_i) begin
    a1_q   <= a_d;
    neg1_q <= neg_d;
    n_q[0] <= ISW'((2 * OPW)'(sub_a) * (2 * OPW)'(add_a));
    r_q[0] <= '0;
    sa_q[0] <= a1_q;
    sn_q[0] <= neg1_q;
  end

  // Integer square root, two radicand bits per stage
  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
    localparam logic [ISW-1:0] BIT_J = ISW'(1) << (ISW - 1 - 2 * j);
    logic [ISW-1:0] trial;
    logic           fits;
    assign trial = r_q[j] + BIT_J;
    assign fits  = n_q[j] >= trial;

    if (j < ISQ_STEPS - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        n_q[j+1] <= fits ? n_q[j] - trial : n_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      r_q[j+1]  <= fits ? (r_q[j] >> 1) + BIT_J : r_q[j] >> 1;
      sa_q[j+1] <= sa_q[j];
      sn_q[j+1] <= sn_q[j];
    end
  end

  // Vectoring CORDIC on (a, sqrt(1 - a^2)) drives y to zero
  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    localparam logic signed [AW-1:0] ATAN_I = atan_f(i);
    logic signed [AW-1:0] xc, yc, zc_i;
    logic                 nc;

    if (i == 0) begin : g_first
      assign xc   = signed'(AW'(sa_q[ISQ_STEPS]));
      assign yc   = signed'(AW'(r_q[ISQ_STEPS]));
      assign zc_i = '0;
      assign nc   = sn_q[ISQ_STEPS];
    end else begin : g_next
      assign xc   = vx_q[i];
      assign yc   = vy_q[i];
      assign zc_i = vz_q[i];
      assign nc   = vn_q[i];
    end

    if (i < STEPS - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        vx_q[i+1] <= (yc > 0) ? xc + (yc >>> i) : xc - (yc >>> i);
        vy_q[i+1] <= (yc > 0) ? yc - (xc >>> i) : yc + (xc >>> i);
      end
    end
    always_ff @(posedge clk_i) begin
      vz_q[i+1] <= (yc > 0) ? zc_i + ATAN_I : zc_i - ATAN_I;
      vn_q[i+1] <= nc;
    end
  end

  // Final stage: no negative angle, reflect for a negative cosine
  assign zc = vz_q[STEPS][AW-1] ? '0 : vz_q[STEPS];

  always_ff @(posedge clk_i) begin
    ang_q <= vn_q[STEPS] ? AW'(PI_F - zc) : AW'(zc);
  end

  assign angle_o = ang_q;

endmodule

@@ rtl/great_circle_distance.sv @@
// Top level of the great-circle distance block: input register, cosine-sum
// products and scaling to metres. Uses gcd_pkg, gcd_trig, gcd_acos and the defines header.
//
// Usage: drive lon_a_i, lat_a_i, lon_b_i, lat_b_i (microdegrees) and
// same_vertex_i with start high; the beat is taken at that edge, as busy
// never rises. The pipeline takes a new beat in every cycle.
// Result: done_o is high for exactly one cycle when the beat leaves the
// pipeline, with distance_m_o valid alongside (0.99 x 6378 km x the central
// angle, truncated metres; 0 when same_vertex_i was set).
// Throughput: one pair per cycle. The pipeline holds the input register,
// 36 trig stages (4 reduction and 32 CORDIC), 3 product stages, 67
// arc-cosine stages (2 set-up, 32 square root, 32 CORDIC, 1 final) and
// the output register.
// Reset clears the control lines only; beats in flight are dropped and no
// done_o follows. The receiver cannot stall: each result stands for one
// cycle only.
module great_circle_distance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [gcd_pkg::LON_W-1:0] lon_a_i,
  input  logic signed [gcd_pkg::LAT_W-1:0] lat_a_i,
  input  logic signed [gcd_pkg::LON_W-1:0] lon_b_i,
  input  logic signed [gcd_pkg::LAT_W-1:0] lat_b_i,
  input  logic                          same_vertex_i,
  output logic                          done_o,
  output logic [gcd_pkg::DW-1:0]        distance_m_o
);
  import gcd_pkg::*;
  `include "great_circle_distance_defines.svh"

  localparam int LATENCY = 1 + TRIG_LAT + 3 + ACOS_LAT + 1;
  localparam logic [DW-1:0] DIST_MAX = DW'(19900000);
  localparam int DPW = AW + 23;

  // Signed magnitude product, truncated in magnitude
  function automatic logic signed [AW-1:0] mulq(input logic signed [AW-1:0] a,
                                                input logic signed [AW-1:0] b);
    logic [AW-1:0]   ma, mb, m;
    logic [2*AW-1:0] p;
    ma = a[AW-1] ? AW'(-a) : AW'(a);
    mb = b[AW-1] ? AW'(-b) : AW'(b);
    p  = (2 * AW)'(ma) * (2 * AW)'(mb);
    m  = p[FRAC +: AW];
    return (a[AW-1] ^ b[AW-1]) ? signed'(-m) : signed'(m);
  endfunction

  tag_t                 in_tag_q;
  logic signed [UW-1:0] udeg_q [LANES];
  tag_t                 trig_tag;
  logic signed [AW-1:0] cos_w [LANES];
  logic signed [AW-1:0] sin_w [LANES];
  tag_t                 mt_q [3];
  logic signed [AW-1:0] mab_q, mcc_q, cd_q, mab2_q, m2_q;
  logic signed [SW-1:0] sum_q;
  tag_t                 acos_tag;
  logic [AW-1:0]        angle;
  logic [DPW-1:0]       dprod;
  logic                 done_q;
  logic [DW-1:0]        dist_q;

  // The pipeline never holds a beat back
  assign busy = 1'b0;

  // Input register and control line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q <= '0;
      for (int j = 0; j < 3; j++) mt_q[j] <= '0;
      done_q   <= 1'b0;
    end else begin
      in_tag_q.valid <= start && !busy;
      in_tag_q.same  <= same_vertex_i;
      mt_q[0]        <= trig_tag;
      mt_q[1]        <= mt_q[0];
      mt_q[2]        <= mt_q[1];
      done_q         <= acos_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    udeg_q[0] <= {{(UW - LAT_W){lat_a_i[LAT_W-1]}}, lat_a_i};
    udeg_q[1] <= {{(UW - LAT_W){lat_b_i[LAT_W-1]}}, lat_b_i};
    udeg_q[2] <= {lon_a_i[LON_W-1], lon_a_i} - {lon_b_i[LON_W-1], lon_b_i};
  end

  gcd_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (in_tag_q),
    .udeg_i (udeg_q),
    .tag_o  (trig_tag),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  // Cosine sum: sinA sinB + cos(dlon) (cosA cosB); both lane products, then the longitude product, then the sum
  always_ff @(posedge clk_i) begin
    mab_q  <= mulq(sin_w[0], sin_w[1]);
    mcc_q  <= mulq(cos_w[0], cos_w[1]);
    cd_q   <= cos_w[2];
    mab2_q <= mab_q;
    m2_q   <= mulq(cd_q, mcc_q);
    sum_q  <= {mab2_q[AW-1], mab2_q} + {m2_q[AW-1], m2_q};
  end

  gcd_acos u_acos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (mt_q[2]),
    .sum_i   (sum_q),
    .tag_o   (acos_tag),
    .angle_o (angle)
  );

  // Scale the angle to metres
  assign dprod = DPW'(angle) * DPW'(METER_SCALE);

  always_ff @(posedge clk_i) begin
    dist_q <= acos_tag.same ? '0 : dprod[FRAC +: DW];
  end

  assign done_o       = done_q;
  assign distance_m_o = dist_q;

  // Checks on beat flow and result range
  `GCD_ASSERT_DLY(a_done_follows, clk_i, rst_ni, start && !busy, LATENCY, done_o)
  `GCD_ASSERT_DLY(a_no_spurious, clk_i, rst_ni, !(start && !busy), LATENCY, !done_o)
  `GCD_ASSERT_DLY(a_same_zero, clk_i, rst_ni, start && !busy && same_vertex_i, LATENCY, distance_m_o == '0)
  `GCD_ASSERT_IMP(a_dist_range, clk_i, rst_ni, done_o, distance_m_o <= DIST_MAX)

endmodule
